[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define OBRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OBRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/obrb_pkg.sv]
// Shared types, widths and codes for the overwriting byte ring buffer.
package obrb_pkg;

    localparam int SIZE_W       = 9;
    localparam int LEN_W        = 9;
    localparam int BYTE_W       = 8;
    localparam int DEPTH_DEF    = 256;
    localparam int MAX_READ_DEF = 64;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SIZE_IDX = 1'b0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              data_valid;
        logic              status;
        logic              last;
        logic [SIZE_W-1:0] fill_level;
    } rsp_t;

    typedef struct packed {
        logic take;   // accept the request beat
        logic issue;  // read one byte at the head
        logic load;   // move the read byte into the response register
    } ctrl_cmd_t;

    typedef struct packed {
        logic rd_go;      // current request is a read that streams bytes
        logic rd_last;    // byte just issued is the last of the read
        logic slot_free;  // response register can take a beat
    } dp_sts_t;

endpackage

[rtl/obrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module obrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/obrb_ctrl.sv]
// Controller: sequences request acceptance and the byte-by-byte read stream.
module obrb_ctrl import obrb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_DATA
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = sts.slot_free;
                cmd.take  = req_valid && sts.slot_free;
                if (cmd.take && sts.rd_go)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.issue  = 1'b1;
                state_next = S_DATA;
            end
            S_DATA:
            begin
                // RAM output holds until the response register frees up
                if (sts.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.rd_last ? S_IDLE : S_ADDR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/obrb_dp.sv]
// Datapath: size register, ring pointers, fill count, byte store, response register.
module obrb_dp import obrb_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    output logic [SIZE_W-1:0] size_value,
    input  req_t              req,
    input  ctrl_cmd_t         cmd,
    output dp_sts_t           sts,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp
);

    localparam int          PTR_W      = $clog2(DEPTH);
    localparam int          CNT_W      = $clog2(MAX_READ + 1);
    localparam logic [31:0] DEPTH_L    = 32'(DEPTH);
    localparam logic [31:0] MAX_READ_L = 32'(MAX_READ);

    logic [SIZE_W-1:0] size_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [SIZE_W-1:0] fill_reg;
    logic [LEN_W-1:0]  left_reg;
    logic              rej_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rd_last_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [SIZE_W-1:0] eff_size;
    logic              size_zero;
    logic [PTR_W-1:0]  tail_inc;
    logic [PTR_W-1:0]  head_inc;
    logic              full;

    logic              wr_new;
    logic              rej_now;
    logic              wr_zero;
    logic              wr_store;
    logic [LEN_W-1:0]  left_cur;
    logic [LEN_W-1:0]  left_dec;
    logic              wr_end;
    logic [SIZE_W-1:0] fill_after;

    logic              rd_rej;
    logic              rd_zero;
    logic              is_write;
    logic              take_emit;
    rsp_t              take_rsp;
    logic              slot_free;
    logic [BYTE_W-1:0] ram_rdata;

    // sizes above the store depth act as the depth
    assign eff_size  = (32'(size_reg) > DEPTH_L) ? DEPTH_L[SIZE_W-1:0] : size_reg;
    assign size_zero = (eff_size == '0);

    assign tail_inc = (32'(tail_reg) + 32'd1 == 32'(eff_size)) ? '0 : PTR_W'(tail_reg + 1'b1);
    assign head_inc = (32'(head_reg) + 32'd1 == 32'(eff_size)) ? '0 : PTR_W'(head_reg + 1'b1);
    assign full     = (fill_reg >= eff_size);

    // write beat
    assign is_write = (req.operation == OP_WRITE);
    assign wr_new   = (left_reg == '0);
    assign rej_now  = wr_new ? (size_zero || ({req.length, 1'b0} > {1'b0, eff_size}))
                             : rej_reg;
    assign wr_zero  = wr_new && (req.length == '0);
    assign wr_store = !wr_zero && !rej_now && !size_zero;
    assign left_cur = wr_new ? req.length : left_reg;
    assign left_dec = left_cur - 1'b1;
    assign wr_end   = wr_zero || (left_dec == '0);

    always_comb
    begin
        fill_after = fill_reg;
        if (wr_store && !full)
        begin
            fill_after = fill_reg + 1'b1;
        end
    end

    // read request
    assign rd_rej  = size_zero || (req.length > fill_reg) || (32'(req.length) > MAX_READ_L);
    assign rd_zero = (req.length == '0);

    always_comb
    begin
        take_rsp          = '0;
        take_rsp.last     = 1'b1;
        take_emit         = 1'b0;
        if (is_write)
        begin
            take_emit           = wr_end;
            take_rsp.status     = rej_now ? STATUS_REJECT : STATUS_OK;
            take_rsp.fill_level = fill_after;
        end
        else
        begin
            take_emit           = rd_rej || rd_zero;
            take_rsp.status     = rd_rej ? STATUS_REJECT : STATUS_OK;
            take_rsp.fill_level = fill_reg;
        end
    end

    assign slot_free     = !out_valid_reg || rsp_ready;
    assign sts.slot_free = slot_free;
    assign sts.rd_go     = (req.operation == OP_READ) && !rd_rej && !rd_zero;
    assign sts.rd_last   = rd_last_reg;

    obrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.take && is_write && wr_store),
        .waddr (tail_reg),
        .wdata (req.data_byte),
        .re    (cmd.issue),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            left_reg      <= '0;
            rej_reg       <= 1'b0;
            cnt_reg       <= '0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
                head_reg <= '0;
                tail_reg <= '0;
                fill_reg <= '0;
                left_reg <= '0;
                rej_reg  <= 1'b0;
            end
            else if (cmd.take)
            begin
                if (is_write)
                begin
                    if (wr_store)
                    begin
                        tail_reg <= tail_inc;
                        if (full)
                        begin
                            head_reg <= head_inc;
                        end
                    end
                    fill_reg <= fill_after;
                    left_reg <= wr_zero ? '0 : left_dec;
                    rej_reg  <= wr_end ? 1'b0 : rej_now;
                end
                else
                begin
                    cnt_reg <= req.length[CNT_W-1:0];
                end
            end
            else if (cmd.issue)
            begin
                head_reg    <= head_inc;
                fill_reg    <= fill_reg - 1'b1;
                cnt_reg     <= cnt_reg - 1'b1;
                rd_last_reg <= (cnt_reg == CNT_W'(1));
            end

            if ((cmd.take && take_emit) || cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && take_emit)
        begin
            out_reg <= take_rsp;
        end
        else if (cmd.load)
        begin
            out_reg.data_out   <= ram_rdata;
            out_reg.data_valid <= 1'b1;
            out_reg.status     <= STATUS_OK;
            out_reg.last       <= rd_last_reg;
            out_reg.fill_level <= fill_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;
    assign size_value = size_reg;

endmodule

[rtl/overwriting_byte_ring_buffer_top.sv]
// Top level of the overwriting byte ring buffer.
//
//  channel | direction | handshake                     | beat
//  req     | in        | req_valid / req_ready         | req_t: operation, length, data_byte
//  rsp     | out       | rsp_valid / rsp_ready         | rsp_t: data_out .. fill_level
//  apb     | in        | psel, penable, pwrite, pready | size_in_use at paddr 0
//
// A read streams its bytes after its request beat, one RAM read and one response
// load per byte through the single registered read port; no new request beat is
// taken until its last byte is loaded.
// Status-only responses leave in the cycle after the request beat.
// A stalled rsp holds the response register and blocks new request beats.
// rst_n clears size, pointers and fill count; the byte store is not cleared.
module overwriting_byte_ring_buffer_top import obrb_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    ctrl_cmd_t         cmd;
    dp_sts_t           sts;
    logic              cfg_we;
    logic              size_sel;
    logic [SIZE_W-1:0] size_value;

    assign pready   = 1'b1;
    assign size_sel = (paddr[APB_ADDR_W-1] == REG_SIZE_IDX);
    assign cfg_we   = psel && penable && pwrite && size_sel;
    assign prdata   = size_sel ? APB_DATA_W'(size_value) : '0;

    obrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    obrb_dp #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[SIZE_W-1:0]),
        .size_value (size_value),
        .req        (req),
        .cmd        (cmd),
        .sts        (sts),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

[rtl/obrb_checker.sv]
// Port-level checker for the ring buffer, bound to the top level.
`include "assert_macros.svh"

module obrb_checker import obrb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    localparam logic [31:0] FILL_MAX = (DEPTH < 511) ? 32'(DEPTH) : 32'd511;

    `OBRB_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp beat changed while stalled")
    `OBRB_ASSERT(a_data_ok, clk, rst_n, rsp_valid && rsp.data_valid |-> rsp.status == STATUS_OK, "read byte carries reject status")
    `OBRB_ASSERT(a_status_only, clk, rst_n, rsp_valid && !rsp.data_valid |-> rsp.last && rsp.data_out == '0, "status beat not last or data nonzero")
    `OBRB_ASSERT(a_fill_bound, clk, rst_n, rsp_valid |-> 32'(rsp.fill_level) <= FILL_MAX, "fill level above store depth")
    `OBRB_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !rsp_valid, "rsp valid during reset")

endmodule

bind overwriting_byte_ring_buffer_top obrb_checker #(
    .DEPTH (DEPTH)
) u_obrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/overwriting_byte_ring_buffer_top_tb.sv]
// Self-checking testbench for the overwriting byte ring buffer: directed and random traffic.
`timescale 1ns / 100ps

module overwriting_byte_ring_buffer_top_tb import obrb_pkg::*; ();

    localparam int IDX_W          = $clog2(DEPTH_DEF);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predicted ring state
    logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
    logic [IDX_W-1:0]  ring_head = '0;
    logic [IDX_W-1:0]  ring_tail = '0;
    logic [SIZE_W-1:0] ring_fill = '0;
    logic [LEN_W-1:0]  xfer_left = '0;
    logic              xfer_bad  = 1'b0;
    logic [SIZE_W-1:0] size_reg  = '0;

    rsp_t rsp_due[$];
    rsp_t rsp_want;

    int mismatches    = 0;
    int beats_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;

    overwriting_byte_ring_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic int eff_size();
        return (size_reg > DEPTH_DEF) ? DEPTH_DEF : int'(size_reg);
    endfunction

    function automatic void push_rsp(input logic [BYTE_W-1:0] d, input logic v,
                                     input logic st, input logic l);
        rsp_t b;
        b.data_out   = d;
        b.data_valid = v;
        b.status     = st;
        b.last       = l;
        b.fill_level = ring_fill;
        rsp_due.push_back(b);
    endfunction

    // Advance the predicted ring by one accepted request beat.
    function automatic void ring_apply(input req_t r);
        int                eff;
        int                k;
        logic [BYTE_W-1:0] rd_byte;
        eff = eff_size();
        if (r.operation == OP_WRITE)
        begin
            if (xfer_left == 0)
            begin
                xfer_bad = (eff == 0 || 2 * int'(r.length) > eff);
                if (r.length == 0)
                begin
                    push_rsp('0, 1'b0, xfer_bad ? STATUS_REJECT : STATUS_OK, 1'b1);
                    xfer_bad = 1'b0;
                    return;
                end
                xfer_left = r.length;
            end
            if (!xfer_bad && eff != 0)
            begin
                ring_mem[ring_tail] = r.data_byte;
                ring_tail = IDX_W'((int'(ring_tail) + 1) % eff);
                // full: oldest byte is dropped
                if (int'(ring_fill) >= eff)
                    ring_head = IDX_W'((int'(ring_head) + 1) % eff);
                else
                    ring_fill++;
            end
            xfer_left--;
            if (xfer_left == 0)
            begin
                push_rsp('0, 1'b0, xfer_bad ? STATUS_REJECT : STATUS_OK, 1'b1);
                xfer_bad = 1'b0;
            end
        end
        else if (eff == 0 || r.length > ring_fill || r.length > MAX_READ_DEF)
            push_rsp('0, 1'b0, STATUS_REJECT, 1'b1);
        else if (r.length == 0)
            push_rsp('0, 1'b0, STATUS_OK, 1'b1);
        else
        begin
            for (k = 0; k < int'(r.length); k++)
            begin
                rd_byte = ring_mem[ring_head];
                ring_head = IDX_W'((int'(ring_head) + 1) % eff);
                ring_fill--;
                push_rsp(rd_byte, 1'b1, STATUS_OK, (k + 1 == int'(r.length)));
            end
        end
    endfunction

    function automatic req_t make_beat(input logic op, input int len, input int data);
        req_t it;
        it.operation = op;
        it.length    = LEN_W'(len);
        it.data_byte = BYTE_W'(data);
        return it;
    endfunction

    // Leaves req_valid high; wait_drained lowers it.
    task automatic send_beat(input req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        ring_apply(item);
        beats_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_SIZE_IDX, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Size write clears the pointers and drops any open transfer.
    task automatic set_ring_size(input logic [SIZE_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        wait_drained();
        apb_access(1'b1, APB_DATA_W'(v), rd);
        size_reg  = v;
        ring_head = '0;
        ring_tail = '0;
        ring_fill = '0;
        xfer_left = '0;
        xfer_bad  = 1'b0;
        @(posedge clk);
        apb_access(1'b0, '0, rd);
        check_field("size_in_use readback", 16'(rd[SIZE_W-1:0]), 16'(v));
    endtask

    task automatic send_read(input int len);
        send_beat(make_beat(OP_READ, len, $urandom_range(0, 255)));
    endtask

    function automatic int pick_read_len();
        int r;
        int fill;
        int lo;
        r    = $urandom_range(0, 99);
        fill = int'(ring_fill);
        lo   = (fill + 1 > 256) ? 256 : fill + 1;
        if (r < 10)
            return 0;
        if (r < 20)
            return $urandom_range(lo, (lo + 7 > 256) ? 256 : lo + 7);
        if (r < 28)
            return (fill > MAX_READ_DEF) ? $urandom_range(MAX_READ_DEF + 1, fill)
                                         : $urandom_range(MAX_READ_DEF + 1, 256);
        if (r < 40)
            return (fill > MAX_READ_DEF) ? MAX_READ_DEF : fill;
        return $urandom_range(0, (fill > MAX_READ_DEF) ? MAX_READ_DEF : fill);
    endfunction

    function automatic int pick_write_len();
        int r;
        int max_ok;
        int cap;
        r      = $urandom_range(0, 99);
        max_ok = eff_size() / 2;
        if (r < 10)
            return 0;
        // rejected lengths only where the transfer stays short
        if (r < 22 && eff_size() <= 64)
            return max_ok + 1 + $urandom_range(0, 2);
        cap = (max_ok > 48) ? 48 : max_ok;
        if (cap == 0)
            return 0;
        return $urandom_range(1, cap);
    endfunction

    // One write transfer; noise changes the length field on later beats.
    task automatic send_write(input int len, input int noise_pct, input int read_pct);
        req_t it;
        int   i;
        int   n;
        n = (len == 0) ? 1 : len;
        for (i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < read_pct)
                send_read(pick_read_len());
            it = make_beat(OP_WRITE, len, $urandom_range(0, 255));
            if (i > 0 && $urandom_range(0, 99) < noise_pct)
                it.length = LEN_W'($urandom_range(0, 256));
            send_beat(it);
        end
    endtask

    task automatic test_uninitialised();
        send_beat(make_beat(OP_WRITE, 2, 8'h00));
        send_beat(make_beat(OP_WRITE, 2, 8'hFF));
        send_beat(make_beat(OP_WRITE, 0, 8'h5A));
        send_read(0);
        send_read(1);
        set_ring_size(9'd0);
        send_read(0);
    endtask

    task automatic test_tiny_size();
        set_ring_size(9'd1);
        send_beat(make_beat(OP_WRITE, 1, 8'hC3));
        send_beat(make_beat(OP_WRITE, 0, 8'h3C));
        send_read(0);
    endtask

    task automatic test_fill_and_overwrite();
        set_ring_size(9'd4);
        send_beat(make_beat(OP_WRITE, 2, 8'h00));
        send_beat(make_beat(OP_WRITE, 2, 8'hFF));
        send_write(3, 0, 0);
        send_beat(make_beat(OP_WRITE, 2, 8'hA5));
        send_beat(make_beat(OP_WRITE, 2, 8'h5A));
        send_beat(make_beat(OP_WRITE, 2, 8'h3C));
        send_beat(make_beat(OP_WRITE, 2, 8'hC3));
        send_read(5);
        send_read(4);
        send_read(0);
    endtask

    task automatic test_read_in_open_write();
        set_ring_size(9'd8);
        send_beat(make_beat(OP_WRITE, 4, 8'h11));
        send_beat(make_beat(OP_WRITE, 4, 8'h22));
        send_read(1);
        // latched count governs, not this length
        send_beat(make_beat(OP_WRITE, 9, 8'h33));
        send_beat(make_beat(OP_WRITE, 4, 8'h44));
        send_read(256);
    endtask

    task automatic test_size_write_abandons();
        send_beat(make_beat(OP_WRITE, 3, 8'h77));
        set_ring_size(9'd256);
        send_beat(make_beat(OP_WRITE, 1, 8'h88));
        send_read(1);
    endtask

    task automatic run_random_phase(input logic [SIZE_W-1:0] sz, input int idle_pct,
                                    input int stall, input int budget, input int bulk_len);
        int start;
        int roll;
        set_ring_size(sz);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start         = beats_sent;
        if (bulk_len > 0)
            send_write(bulk_len, 0, 0);
        while (beats_sent - start < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                wait_drained();
            else if (roll < 55)
                send_write(pick_write_len(), 8, 6);
            else
                send_read(pick_read_len());
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(9'd16, 0, 0, 60, 0);
        run_random_phase(9'd7, 52, 0, 60, 0);
        run_random_phase(9'd256, 0, 52, 140, 80);
        // above DEPTH acts as DEPTH, so 129 is too long
        run_random_phase(9'd511, 29, 29, 170, 129);
        run_random_phase(9'd2, 29, 29, 40, 0);
    endtask

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (rsp_due.size() == 0)
                report_mismatch($sformatf("unexpected beat data %0h status %0b",
                                          rsp.data_out, rsp.status));
            else
            begin
                rsp_want = rsp_due.pop_front();
                check_field("data_out", 16'(rsp.data_out), 16'(rsp_want.data_out));
                check_field("data_valid", 16'(rsp.data_valid), 16'(rsp_want.data_valid));
                check_field("status", 16'(rsp.status), 16'(rsp_want.status));
                check_field("last", 16'(rsp.last), 16'(rsp_want.last));
                check_field("fill_level", 16'(rsp.fill_level), 16'(rsp_want.fill_level));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
            || (psel && penable && pready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // driven at time 0 so the asynchronous reset sees a falling edge
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_uninitialised();
        test_tiny_size();
        test_fill_and_overwrite();
        test_read_in_open_write();
        test_size_write_abandons();
        test_random_traffic();
        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
